FILE: rtl/core/mdcf_pkg.sv
// Shared constants, register codes and types for the modulated delay chorus/flanger.
package mdcf_pkg;

  localparam int MAX_DELAY_ENTRIES = 2048;
  localparam int SAMPLE_BITS       = 16;

  localparam int GAIN_W   = 16;
  localparam int DELAY_W  = 11;
  localparam int PHASE_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_A_W  = 34;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH         = 3'd0,
    REG_EXCURSION     = 3'd1,
    REG_FEEDBACK_GAIN = 3'd2,
    REG_DELAY_SAMPLES = 3'd3,
    REG_LFO_STEP      = 3'd4
  } mdcf_reg_t;

  localparam logic [GAIN_W-1:0]  DEPTH_RESET     = 16'd16384;
  localparam logic [GAIN_W-1:0]  EXCURSION_RESET = 16'd16384;
  localparam logic [GAIN_W-1:0]  FEEDBACK_RESET  = 16'd0;
  localparam logic [DELAY_W-1:0] DELAY_RESET     = 11'd960;
  localparam logic [PHASE_W-1:0] LFO_STEP_RESET  = 32'd89478;

  typedef struct packed {
    logic en;
    logic accum;
  } mdcf_mac_ctl_t;

endpackage

FILE: rtl/core/mdcf_if.sv
// Handshake interfaces for the sample input, sample output and configuration channels.
interface mdcf_in_if #(
  parameter int SAMPLE_BITS = mdcf_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface mdcf_out_if #(
  parameter int SAMPLE_BITS = mdcf_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface mdcf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mdcf_pkg::CFG_IDX_W-1:0]    index;
  logic [mdcf_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/mdcf_mac.sv
// Shared signed multiply-accumulate unit with a registered accumulator.
module mdcf_mac #(
  parameter int A_W = mdcf_pkg::MUL_A_W,
  parameter int B_W = 18
) (
  input  logic                        clk,
  input  mdcf_pkg::mdcf_mac_ctl_t     ctl,
  input  logic signed [A_W-1:0]       a,
  input  logic signed [B_W-1:0]       b,
  output logic signed [A_W+B_W-1:0]   acc_r
);

  logic signed [A_W+B_W-1:0] prod;
  logic signed [A_W+B_W-1:0] acc_nxt;

  always_comb begin
    prod    = a * b;
    acc_nxt = ctl.accum ? acc_r + prod : prod;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

FILE: rtl/core/modulated_delay_chorus_flanger.sv
// Top level of the modulated delay chorus/flanger: sequencer, delay store and output register.
//
//   channel  direction  payload                         transfer when
//   in_ch    sink       sample_in                       in_ch.valid & in_ch.ready
//   out_ch   source     sample_out                      out_ch.valid & out_ch.ready
//   cfg_ch   sink       index (3 bits), data (32 bits)  cfg_ch.valid & cfg_ch.ready
//
// Each sample runs through the states MOD (only when the write slot first has to be reduced
// after the delay length shrank), TRI, CLAMP, DMUL, ADDR, RD1, RD2, INT2, DRY, WET, FB and
// DONE; the shared multiply-accumulate unit, used seven times per sample, and the two delay
// store reads set this sequence. A new sample is taken only once the last one leaves DONE.
// After reset all MAX_DELAY_ENTRIES delay store entries are cleared with in_ch.ready low.
// A finished result waits in the output register while the next sample is transferred in;
// the final cycle of a sample stalls only while a previous result is still untaken.
module modulated_delay_chorus_flanger #(
  parameter int MAX_DELAY_ENTRIES = mdcf_pkg::MAX_DELAY_ENTRIES,
  parameter int SAMPLE_BITS       = mdcf_pkg::SAMPLE_BITS
) (
  input logic clk,
  input logic rst_n,
  mdcf_in_if.sink    in_ch,
  mdcf_out_if.source out_ch,
  mdcf_cfg_if.sink   cfg_ch
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(MAX_DELAY_ENTRIES);
  localparam int DW = mdcf_pkg::DELAY_W;
  localparam int GW = mdcf_pkg::GAIN_W;
  localparam int PHW = mdcf_pkg::PHASE_W;
  localparam int MAW = mdcf_pkg::MUL_A_W;
  localparam int BW = (SB + 1 > 18) ? SB + 1 : 18;
  localparam int PW = MAW + BW;
  localparam int D_LIMIT_I = (MAX_DELAY_ENTRIES - 1 < 2047) ? MAX_DELAY_ENTRIES - 1 : 2047;
  localparam logic [DW-1:0] D_LIMIT = DW'(D_LIMIT_I);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_DELAY_ENTRIES - 1);
  localparam logic signed [PW-1:0] SAT_HI = PW'(2 ** (SB - 1) - 1);
  localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [PW-1:0] ROUND_HALF = PW'(32768);
  localparam logic [3:0] MOD_TOP = 4'(DW - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MOD, ST_TRI, ST_CLAMP, ST_DMUL, ST_ADDR,
    ST_RD1, ST_RD2, ST_INT2, ST_DRY, ST_WET, ST_FB, ST_DONE
  } state_t;

  function automatic logic signed [SB-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] c;
    c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return SB'(c);
  endfunction

  state_t state_r, state_nxt;

  logic [GW-1:0]         depth_r, depth_nxt;
  logic [GW-1:0]         exc_r, exc_nxt;
  logic signed [GW-1:0]  fb_r, fb_nxt;
  logic [DW-1:0]         delay_r, delay_nxt;
  logic [PHW-1:0]        step_r, step_nxt;
  logic [DW-1:0]         wslot_r, wslot_nxt;
  logic [PHW-1:0]        phase_r, phase_nxt;
  logic [AW-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [SB-1:0]  out_sample_r, out_sample_nxt;

  logic signed [SB-1:0]  x_r, x_nxt;
  logic [DW-1:0]         p_r, p_nxt;
  logic [DW-1:0]         rem_r, rem_nxt;
  logic [3:0]            bit_cnt_r, bit_cnt_nxt;
  logic [32:0]           m_r, m_nxt;
  logic [DW-1:0]         a1_r, a1_nxt;
  logic [DW-1:0]         a2_r, a2_nxt;
  logic [7:0]            f_r, f_nxt;
  logic signed [SB-1:0]  s_r, s_nxt;
  logic signed [SB-1:0]  y_r, y_nxt;

  logic signed [SB-1:0]  mem [MAX_DELAY_ENTRIES];
  logic signed [SB-1:0]  rd_data_r;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic signed [SB-1:0]  wr_data;

  mdcf_pkg::mdcf_mac_ctl_t mac_ctl;
  logic signed [MAW-1:0] mac_a;
  logic signed [BW-1:0]  mac_b;
  logic signed [PW-1:0]  acc_r;

  logic [DW-1:0]         d_lim;
  logic [DW:0]           n_c;
  logic [17:0]           q_c;
  logic signed [18:0]    tri_w;
  logic signed [17:0]    tri_c;
  logic signed [35:0]    m_full;
  logic [DW-1:0]         i_raw, i_c, j_c;
  logic [DW:0]           sum1, sum2, rem_shift;
  logic signed [SB-1:0]  w_c;
  logic                  out_free;
  logic                  in_xfer, out_xfer, cfg_xfer;

  mdcf_mac #(
    .A_W (MAW),
    .B_W (BW)
  ) u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .a     (mac_a),
    .b     (mac_b),
    .acc_r (acc_r)
  );

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;

  assign in_xfer  = in_ch.valid & in_ch.ready;
  assign out_xfer = out_valid_r & out_ch.ready;
  assign cfg_xfer = cfg_ch.valid & cfg_ch.ready;
  assign out_free = ~out_valid_r | out_ch.ready;

  always_comb begin
    d_lim = (delay_r > D_LIMIT) ? D_LIMIT : delay_r;
    n_c   = {1'b0, d_lim} + {{DW{1'b0}}, 1'b1};

    q_c   = phase_r[PHW-1:14];
    tri_w = q_c[17] ? (19'sd196608 - $signed({1'b0, q_c}))
                    : ($signed({1'b0, q_c}) - 19'sd65536);
    tri_c = 18'(tri_w);

    m_full = 36'sh080000000 - $signed(acc_r[35:0]);

    i_raw = acc_r[42:32];
    i_c   = (i_raw > d_lim) ? d_lim : i_raw;
    j_c   = (i_c == d_lim) ? '0 : i_c + {{(DW-1){1'b0}}, 1'b1};
    sum1  = {1'b0, p_r} + {1'b0, i_c};
    sum2  = {1'b0, p_r} + {1'b0, j_c};

    rem_shift = {rem_r, wslot_r[bit_cnt_r]};

    w_c = sat(PW'(x_r) + (acc_r >>> 15));
  end

  always_comb begin
    state_nxt      = state_r;
    depth_nxt      = depth_r;
    exc_nxt        = exc_r;
    fb_nxt         = fb_r;
    delay_nxt      = delay_r;
    step_nxt       = step_r;
    wslot_nxt      = wslot_r;
    phase_nxt      = phase_r;
    clr_cnt_nxt    = clr_cnt_r;
    out_valid_nxt  = out_valid_r & ~out_xfer;
    out_sample_nxt = out_sample_r;
    x_nxt          = x_r;
    p_nxt          = p_r;
    rem_nxt        = rem_r;
    bit_cnt_nxt    = bit_cnt_r;
    m_nxt          = m_r;
    a1_nxt         = a1_r;
    a2_nxt         = a2_r;
    f_nxt          = f_r;
    s_nxt          = s_r;
    y_nxt          = y_r;

    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    rd_en   = 1'b0;
    rd_addr = AW'(a1_r);
    wr_en   = 1'b0;
    wr_addr = AW'(p_r);
    wr_data = w_c;

    if (cfg_xfer) begin
      case (cfg_ch.index)
        mdcf_pkg::REG_DEPTH:         depth_nxt = cfg_ch.data[GW-1:0];
        mdcf_pkg::REG_EXCURSION:     exc_nxt   = cfg_ch.data[GW-1:0];
        mdcf_pkg::REG_FEEDBACK_GAIN: fb_nxt    = $signed(cfg_ch.data[GW-1:0]);
        mdcf_pkg::REG_DELAY_SAMPLES: delay_nxt = cfg_ch.data[DW-1:0];
        mdcf_pkg::REG_LFO_STEP:      step_nxt  = cfg_ch.data[PHW-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = '0;
        clr_cnt_nxt = clr_cnt_r + {{(AW-1){1'b0}}, 1'b1};
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          x_nxt = in_ch.sample_in;
          if ({1'b0, wslot_r} >= n_c) begin
            rem_nxt     = '0;
            bit_cnt_nxt = MOD_TOP;
            state_nxt   = ST_MOD;
          end else begin
            p_nxt     = wslot_r;
            state_nxt = ST_TRI;
          end
        end
      end
      ST_MOD: begin
        rem_nxt     = (rem_shift >= n_c) ? DW'(rem_shift - n_c) : DW'(rem_shift);
        bit_cnt_nxt = bit_cnt_r - 4'd1;
        if (bit_cnt_r == 4'd0) begin
          p_nxt     = rem_nxt;
          state_nxt = ST_TRI;
        end
      end
      ST_TRI: begin
        mac_ctl.en = 1'b1;
        mac_a      = MAW'(exc_r);
        mac_b      = BW'(tri_c);
        state_nxt  = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (m_full < 36'sd0) begin
          m_nxt = '0;
        end else if (m_full > 36'sh100000000) begin
          m_nxt = {1'b1, 32'd0};
        end else begin
          m_nxt = m_full[32:0];
        end
        state_nxt = ST_DMUL;
      end
      ST_DMUL: begin
        mac_ctl.en = 1'b1;
        mac_a      = MAW'(m_r);
        mac_b      = BW'($signed({1'b0, d_lim}));
        state_nxt  = ST_ADDR;
      end
      ST_ADDR: begin
        f_nxt     = acc_r[31:24];
        a1_nxt    = (sum1 >= n_c) ? DW'(sum1 - n_c) : DW'(sum1);
        a2_nxt    = (sum2 >= n_c) ? DW'(sum2 - n_c) : DW'(sum2);
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(a1_r);
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        rd_en      = 1'b1;
        rd_addr    = AW'(a2_r);
        mac_ctl.en = 1'b1;
        mac_a      = MAW'(9'd256 - {1'b0, f_r});
        mac_b      = BW'(rd_data_r);
        state_nxt  = ST_INT2;
      end
      ST_INT2: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.accum = 1'b1;
        mac_a         = MAW'(f_r);
        mac_b         = BW'(rd_data_r);
        state_nxt     = ST_DRY;
      end
      ST_DRY: begin
        s_nxt      = SB'(acc_r >>> 8);
        mac_ctl.en = 1'b1;
        mac_a      = MAW'(17'h10000 - {1'b0, depth_r});
        mac_b      = BW'(x_r);
        state_nxt  = ST_WET;
      end
      ST_WET: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.accum = 1'b1;
        mac_a         = MAW'(depth_r);
        mac_b         = BW'(s_r);
        state_nxt     = ST_FB;
      end
      ST_FB: begin
        y_nxt      = sat((acc_r + ROUND_HALF) >>> 16);
        mac_ctl.en = 1'b1;
        mac_a      = MAW'(fb_r);
        mac_b      = BW'(s_r);
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          wr_en          = 1'b1;
          wr_addr        = AW'(p_r);
          wr_data        = w_c;
          out_valid_nxt  = 1'b1;
          out_sample_nxt = y_r;
          wslot_nxt      = (p_r == '0) ? d_lim : p_r - {{(DW-1){1'b0}}, 1'b1};
          phase_nxt      = phase_r + step_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      depth_r     <= mdcf_pkg::DEPTH_RESET;
      exc_r       <= mdcf_pkg::EXCURSION_RESET;
      fb_r        <= $signed(mdcf_pkg::FEEDBACK_RESET);
      delay_r     <= mdcf_pkg::DELAY_RESET;
      step_r      <= mdcf_pkg::LFO_STEP_RESET;
      wslot_r     <= '0;
      phase_r     <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      depth_r      <= depth_nxt;
      exc_r        <= exc_nxt;
      fb_r         <= fb_nxt;
      delay_r      <= delay_nxt;
      step_r       <= step_nxt;
      wslot_r      <= wslot_nxt;
      phase_r      <= phase_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      out_sample_r <= out_sample_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    p_r       <= p_nxt;
    rem_r     <= rem_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    m_r       <= m_nxt;
    a1_r      <= a1_nxt;
    a2_r      <= a2_nxt;
    f_r       <= f_nxt;
    s_r       <= s_nxt;
    y_r       <= y_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
